@@ sv/lrufr_pkg.sv @@
package lrufr_pkg;

  // Frame table geometry
  localparam int FRAME_COUNT = 64;
  localparam int STAMP_BITS  = 32;
  localparam int IDX_W       = $clog2(FRAME_COUNT);
  localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
  localparam int SCAN_W      = $clog2(FRAME_COUNT + 1);

  // Fixed field widths of the transaction ports
  localparam int MODE_W     = 2;
  localparam int FRAME_W    = 6;
  localparam int COUNT_W    = 7;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_ACCESS  = 2'd0,
    MODE_SET_EV  = 2'd1,
    MODE_REMOVE  = 2'd2,
    MODE_EVICT   = 2'd3
  } mode_t;

  // Control from the sequencer to the age compare unit
  typedef struct packed {
    logic             clear;  // any accepted transaction: forget the best so far
    logic             step;   // stamp read data is valid this cycle
    logic             elig;   // entry is tracked and evictable
    logic [IDX_W-1:0] idx;    // entry the read data belongs to
  } scan_ctl_t;

endpackage

@@ sv/lrufr_stamp_ram.sv @@
module lrufr_stamp_ram (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [lrufr_pkg::IDX_W-1:0]         wr_addr,
  input  logic [lrufr_pkg::STAMP_BITS-1:0]    wr_data,
  input  logic [lrufr_pkg::IDX_W-1:0]         rd_addr,
  output logic [lrufr_pkg::STAMP_BITS-1:0]    rd_data
);

  // Last-access stamp per frame, one write and one registered read port
  logic [lrufr_pkg::STAMP_BITS-1:0] mem [lrufr_pkg::FRAME_COUNT];
  logic [lrufr_pkg::STAMP_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/lrufr_age_cmp.sv @@
module lrufr_age_cmp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lrufr_pkg::scan_ctl_t              ctl,
  input  logic [lrufr_pkg::STAMP_BITS-1:0]  stamp_now,
  input  logic [lrufr_pkg::STAMP_BITS-1:0]  stamp_rd,
  output logic                              found,
  output logic [lrufr_pkg::IDX_W-1:0]       best_idx
);

  logic                             found_r;
  logic [lrufr_pkg::STAMP_BITS-1:0] best_age_r;
  logic [lrufr_pkg::IDX_W-1:0]      best_idx_r;
  logic [lrufr_pkg::STAMP_BITS-1:0] age;
  logic                             take;

  // Age wraps modulo the stamp width; strict compare keeps the lowest index on a tie
  assign age  = stamp_now - stamp_rd;
  assign take = ctl.step && ctl.elig && (!found_r || (age > best_age_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  // Best candidate payload
  always_ff @(posedge clk) begin
    if (take) begin
      best_age_r <= age;
      best_idx_r <= ctl.idx;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;

endmodule

@@ sv/lru_frame_replacer_core.sv @@
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_mode, in_frame, in_evictable
// out_      output     out_valid/out_stall out_victim_valid, out_victim_frame,
//                                          out_evictable_count
//
// Access, set evictable and remove complete at the accepting edge: result valid in the next cycle.
// Evict walks every stamp entry through one shared subtract/compare unit over the
// single stamp memory read port, then posts the result from the finish state.
// One transaction is in flight at a time; in_stall is high while busy or while a
// held result is stalled. Synchronous active-low reset clears all frame flags, the
// stamp clock and the evictable count; stamp entries need no clearing.
module lru_frame_replacer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lrufr_pkg::MODE_W-1:0]      in_mode,
  input  logic [lrufr_pkg::FRAME_W-1:0]     in_frame,
  input  logic                              in_evictable,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_victim_valid,
  output logic [lrufr_pkg::FRAME_W-1:0]     out_victim_frame,
  output logic [lrufr_pkg::COUNT_W-1:0]     out_evictable_count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                            state_r;
  logic [lrufr_pkg::FRAME_COUNT-1:0] tracked_r;
  logic [lrufr_pkg::FRAME_COUNT-1:0] may_evict_r;
  logic [lrufr_pkg::STAMP_BITS-1:0]  clock_stamp_r;
  logic [lrufr_pkg::CNT_W-1:0]       ev_total_r;
  logic [lrufr_pkg::SCAN_W-1:0]      scan_cnt_r;
  logic                              rd_vld_r;
  logic                              rd_elig_r;
  logic [lrufr_pkg::IDX_W-1:0]       rd_idx_r;

  logic                              out_valid_r;
  logic                              out_victim_valid_r;
  logic [lrufr_pkg::FRAME_W-1:0]     out_victim_frame_r;
  logic [lrufr_pkg::COUNT_W-1:0]     out_evictable_count_r;

  logic                              accept;
  logic                              post_result;
  logic                              in_range;
  logic [lrufr_pkg::IDX_W-1:0]       fidx;
  logic [lrufr_pkg::IDX_W-1:0]       scan_idx;
  logic                              scan_last;
  lrufr_pkg::mode_t                  mode;
  logic [lrufr_pkg::STAMP_BITS-1:0]  stamp_nxt;
  logic                              ram_wr_en;
  logic [lrufr_pkg::STAMP_BITS-1:0]  ram_rd_data;
  lrufr_pkg::scan_ctl_t              scan_ctl;
  logic                              cmp_found;
  logic [lrufr_pkg::IDX_W-1:0]       cmp_best;

  // Handshake
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // A result is posted at once for non-evict operations, after the scan for evict
  assign post_result = (state_r == ST_FINISH) ||
                       (accept && (mode != lrufr_pkg::MODE_EVICT));

  // Decode of the incoming transaction
  assign mode      = lrufr_pkg::mode_t'(in_mode);
  assign in_range  = 32'(in_frame) < lrufr_pkg::FRAME_COUNT;
  assign fidx      = in_frame[lrufr_pkg::IDX_W-1:0];
  assign stamp_nxt = clock_stamp_r + 1'b1;
  assign ram_wr_en = accept && (mode == lrufr_pkg::MODE_ACCESS) && in_range;

  // Scan address walk
  assign scan_idx  = scan_cnt_r[lrufr_pkg::IDX_W-1:0];
  assign scan_last = (32'(scan_cnt_r) == lrufr_pkg::FRAME_COUNT);

  assign scan_ctl.clear = accept;
  assign scan_ctl.step  = rd_vld_r;
  assign scan_ctl.elig  = rd_elig_r;
  assign scan_ctl.idx   = rd_idx_r;

  lrufr_stamp_ram u_stamp_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fidx),
    .wr_data (stamp_nxt),
    .rd_addr (scan_idx),
    .rd_data (ram_rd_data)
  );

  lrufr_age_cmp u_age_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .stamp_now (clock_stamp_r),
    .stamp_rd  (ram_rd_data),
    .found     (cmp_found),
    .best_idx  (cmp_best)
  );

  // Sequencer, frame flags and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tracked_r     <= '0;
      may_evict_r   <= '0;
      clock_stamp_r <= '0;
      ev_total_r    <= '0;
      scan_cnt_r    <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (post_result) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            out_victim_valid_r <= 1'b0;
            out_victim_frame_r <= '0;
            unique case (mode)
              lrufr_pkg::MODE_ACCESS: begin
                out_evictable_count_r <= lrufr_pkg::COUNT_W'(ev_total_r);
                if (in_range) begin
                  clock_stamp_r <= stamp_nxt;
                  if (!tracked_r[fidx]) begin
                    tracked_r[fidx]   <= 1'b1;
                    may_evict_r[fidx] <= 1'b0;
                  end
                end
              end
              lrufr_pkg::MODE_SET_EV: begin
                if (in_range && tracked_r[fidx] && (may_evict_r[fidx] != in_evictable)) begin
                  may_evict_r[fidx] <= in_evictable;
                  if (in_evictable) begin
                    ev_total_r            <= ev_total_r + 1'b1;
                    out_evictable_count_r <= lrufr_pkg::COUNT_W'(ev_total_r + 1'b1);
                  end else begin
                    ev_total_r            <= ev_total_r - 1'b1;
                    out_evictable_count_r <= lrufr_pkg::COUNT_W'(ev_total_r - 1'b1);
                  end
                end else begin
                  out_evictable_count_r <= lrufr_pkg::COUNT_W'(ev_total_r);
                end
              end
              lrufr_pkg::MODE_REMOVE: begin
                if (in_range && tracked_r[fidx] && may_evict_r[fidx]) begin
                  ev_total_r            <= ev_total_r - 1'b1;
                  out_evictable_count_r <= lrufr_pkg::COUNT_W'(ev_total_r - 1'b1);
                end else begin
                  out_evictable_count_r <= lrufr_pkg::COUNT_W'(ev_total_r);
                end
                if (in_range && tracked_r[fidx]) begin
                  tracked_r[fidx]   <= 1'b0;
                  may_evict_r[fidx] <= 1'b0;
                end
              end
              lrufr_pkg::MODE_EVICT: begin
                scan_cnt_r <= '0;
                state_r    <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          // Issue one stamp read per cycle, tagged with index and eligibility
          if (scan_last) begin
            rd_vld_r <= 1'b0;
            state_r  <= ST_FINISH;
          end else begin
            rd_vld_r   <= 1'b1;
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end
        end
        ST_FINISH: begin
          // Untrack the winner and post the result
          if (cmp_found) begin
            tracked_r[cmp_best]   <= 1'b0;
            may_evict_r[cmp_best] <= 1'b0;
            ev_total_r            <= ev_total_r - 1'b1;
            out_victim_valid_r    <= 1'b1;
            out_victim_frame_r    <= lrufr_pkg::FRAME_W'(cmp_best);
            out_evictable_count_r <= lrufr_pkg::COUNT_W'(ev_total_r - 1'b1);
          end else begin
            out_victim_valid_r    <= 1'b0;
            out_victim_frame_r    <= '0;
            out_evictable_count_r <= lrufr_pkg::COUNT_W'(ev_total_r);
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Read tag pipeline, aligned with the registered memory read
  always_ff @(posedge clk) begin
    rd_idx_r  <= scan_idx;
    rd_elig_r <= tracked_r[scan_idx] && may_evict_r[scan_idx];
  end

  assign out_victim_valid    = out_victim_valid_r;
  assign out_victim_frame    = out_victim_frame_r;
  assign out_evictable_count = out_evictable_count_r;

endmodule
